@@ rtl/vkt_pkg.sv @@
// vkt_pkg: shared types, field widths and codes for the versioned key table.
// No dependencies; imported by every module of the block.
package vkt_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int VER_W   = 31;
	localparam int OFF_W   = 31;
	localparam int LEN_W   = 7;
	localparam int RCNT_W  = 7;
	localparam int STS_W   = 3;

	localparam logic [VER_W-1:0] VERSION_MAX = {VER_W{1'b1}};

	// request operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_VIEW   = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_INSERTED  = 3'd0;
	localparam logic [STS_W-1:0] STS_DELETED   = 3'd1;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd2;
	localparam logic [STS_W-1:0] STS_FULL      = 3'd3;
	localparam logic [STS_W-1:0] STS_ENTRY     = 3'd4;
	localparam logic [STS_W-1:0] STS_EMPTY     = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VER_W-1:0] version;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		entry_t            ent;
		logic [RCNT_W-1:0] removed;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAXSCAN,
		S_FIND,
		S_COMPACT,
		S_VIEW_RD,
		S_VIEW_OUT,
		S_RESP
	} state_t;

endpackage

@@ rtl/vkt_mem.sv @@
// vkt_mem: entry store, one write port and one registered read port.
// Depends on vkt_pkg for the entry layout.
module vkt_mem
	import vkt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/vkt_out_reg.sv @@
// vkt_out_reg: result holding register with valid/ready toward the consumer.
// Depends on vkt_pkg for the result layout.
module vkt_out_reg
	import vkt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t load_res,
	output logic free,
	output logic rsp_valid,
	input  logic rsp_ready,
	output res_t res
);

	logic valid_q;
	res_t res_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

@@ rtl/vkt_seq.sv @@
// vkt_seq: operation sequencer; scans, compacts and lists the entry store.
// Depends on vkt_pkg; drives vkt_mem ports and loads vkt_out_reg.
module vkt_seq
	import vkt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [KEY_W-1:0] key,
	input  logic [VER_W-1:0] version,
	input  logic [OFF_W-1:0] info_offset,
	input  logic [LEN_W-1:0] info_length,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  entry_t           rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output entry_t           wr_data,
	input  logic             out_free,
	output logic             out_load,
	output res_t             out_res
);

	state_t state_q, state_d;

	// control
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] wr_ptr_q;
	logic [CW-1:0] removed_q;
	logic          rd_vld_s1;
	logic          found_q;

	// request payload and working values
	logic [KEY_W-1:0] key_q;
	logic [VER_W-1:0] ver_q;
	logic [OFF_W-1:0] off_q;
	logic [LEN_W-1:0] len_q;
	logic [VER_W-1:0] top_q;
	logic [AW-1:0]    tgt_q;
	logic [AW-1:0]    rd_idx_s1;
	res_t             res_q;

	logic             accept;
	logic             scanning;
	logic             scan_issue;
	logic             scan_done;
	logic             key_hit;
	logic             drop;
	logic [VER_W-1:0] new_ver;

	assign accept     = req_valid && req_ready;
	assign scanning   = (state_q == S_MAXSCAN) || (state_q == S_FIND) ||
	                    (state_q == S_COMPACT);
	assign scan_issue = scanning && (idx_q != count_q);
	assign scan_done  = (idx_q == count_q) && !rd_vld_s1;
	assign key_hit    = rd_data.key == key_q;
	// version 0 drops every match; otherwise only the slot found earlier
	assign drop       = (ver_q == '0) ? key_hit : (rd_idx_s1 == tgt_q);
	assign new_ver    = (top_q == VERSION_MAX) ? VERSION_MAX : top_q + VER_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (operation)
						OP_INSERT: state_d = (count_q == CW'(TABLE_DEPTH)) ? S_RESP : S_MAXSCAN;
						OP_DELETE: state_d = (version == '0) ? S_COMPACT : S_FIND;
						OP_VIEW:   state_d = (count_q == '0) ? S_RESP : S_VIEW_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_MAXSCAN: begin
				if (scan_done) state_d = S_RESP;
			end
			S_FIND: begin
				if (scan_done) state_d = found_q ? S_COMPACT : S_RESP;
			end
			S_COMPACT: begin
				if (scan_done) state_d = S_RESP;
			end
			S_VIEW_RD: state_d = S_VIEW_OUT;
			S_VIEW_OUT: begin
				if (out_free) state_d = (idx_q == '0) ? S_IDLE : S_VIEW_RD;
			end
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = state_q == S_IDLE;
		rd_en     = scan_issue || (state_q == S_VIEW_RD);
		rd_addr   = idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = wr_ptr_q[AW-1:0];
		wr_data   = rd_data;
		out_load  = 1'b0;
		out_res   = res_q;
		case (state_q)
			S_MAXSCAN: begin
				wr_en   = scan_done;
				wr_addr = count_q[AW-1:0];
				wr_data = '{key: key_q, version: new_ver, offset: off_q, length: len_q};
			end
			S_COMPACT: begin
				wr_en = rd_vld_s1 && !drop;
			end
			S_VIEW_OUT: begin
				out_load       = out_free;
				out_res        = '0;
				out_res.status = STS_ENTRY;
				out_res.ent    = rd_data;
				out_res.last   = idx_q == '0;
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			wr_ptr_q  <= '0;
			removed_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (scan_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q     <= (operation == OP_VIEW) ? count_q - CW'(1) : '0;
						wr_ptr_q  <= '0;
						removed_q <= '0;
						found_q   <= 1'b0;
					end
				end
				S_MAXSCAN: begin
					if (scan_done) count_q <= count_q + CW'(1);
				end
				S_FIND: begin
					if (rd_vld_s1 && key_hit && rd_data.version == ver_q) found_q <= 1'b1;
					if (scan_done) idx_q <= '0;
				end
				S_COMPACT: begin
					if (rd_vld_s1) begin
						if (drop) removed_q <= removed_q + CW'(1);
						else      wr_ptr_q  <= wr_ptr_q + CW'(1);
					end
					if (scan_done) count_q <= wr_ptr_q;
				end
				S_VIEW_OUT: begin
					if (out_free && idx_q != '0) idx_q <= idx_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q <= key;
					ver_q <= version;
					off_q <= info_offset;
					len_q <= info_length;
					top_q <= '0;
					res_q <= '{status: (operation == OP_INSERT) ? STS_FULL : STS_EMPTY,
						ent: '0, removed: '0, last: 1'b1};
				end
			end
			S_MAXSCAN: begin
				if (rd_vld_s1 && key_hit && rd_data.version > top_q) top_q <= rd_data.version;
				if (scan_done) begin
					res_q <= '{status: STS_INSERTED,
						ent: '{key: '0, version: new_ver, offset: '0, length: '0},
						removed: '0, last: 1'b1};
				end
			end
			S_FIND: begin
				// later matches override: the newest one wins
				if (rd_vld_s1 && key_hit && rd_data.version == ver_q) tgt_q <= rd_idx_s1;
				if (scan_done) res_q.status <= STS_NOT_FOUND;
			end
			S_COMPACT: begin
				if (scan_done) begin
					res_q <= '{status: (removed_q != '0) ? STS_DELETED : STS_NOT_FOUND,
						ent: '0, removed: RCNT_W'(removed_q), last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/versioned_key_table_core.sv @@
// versioned_key_table_core: top level of the versioned key table.
// Depends on vkt_pkg; instantiates vkt_mem, vkt_seq and vkt_out_reg.
//
// Keeps up to TABLE_DEPTH entries (key, version, info offset, info length)
// in one synchronous memory, oldest in slot 0 and newest at the top.
// Requests are taken one at a time; req_ready is high only while the
// sequencer is idle. The single memory read port sets the speed: an insert
// scans every stored entry once for the highest version of its key. A delete
// by version scans once to find the newest match and, if one is found,
// compacts the table in a second pass; a delete of all versions compacts in
// one pass. A view lists entries newest first, reading each entry and
// passing it to the output register before reading the next, with last set
// on the oldest entry; an empty table answers a single result with status
// empty. An insert into a full table is refused with status full. Versions
// saturate at their maximum. Operation code 3 is accepted and ignored.
// A finished result waits in an output register, so the consumer may stall
// at any time; the sequencer then holds until the register frees up.
module versioned_key_table_core
	import vkt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [KEY_W-1:0]  key,
	input  logic [VER_W-1:0]  version,
	input  logic [OFF_W-1:0]  info_offset,
	input  logic [LEN_W-1:0]  info_length,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [STS_W-1:0]  status,
	output logic [KEY_W-1:0]  entry_key,
	output logic [VER_W-1:0]  entry_version,
	output logic [OFF_W-1:0]  entry_offset,
	output logic [LEN_W-1:0]  entry_length,
	output logic [RCNT_W-1:0] removed_count,
	output logic              last
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          out_free;
	logic          out_load;
	res_t          out_res;
	res_t          res;

	vkt_mem #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	vkt_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.key         (key),
		.version     (version),
		.info_offset (info_offset),
		.info_length (info_length),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.out_free    (out_free),
		.out_load    (out_load),
		.out_res     (out_res)
	);

	vkt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_res  (out_res),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.res       (res)
	);

	assign status        = res.status;
	assign entry_key     = res.ent.key;
	assign entry_version = res.ent.version;
	assign entry_offset  = res.ent.offset;
	assign entry_length  = res.ent.length;
	assign removed_count = res.removed;
	assign last          = res.last;

endmodule

@@ bench/vkt_checker.sv @@
// vkt_checker: watches the request and result channels of the versioned key table,
// keeps its own copy of the table, and compares every result field by field.
// Depends on vkt_pkg for widths, codes and the entry/result structs.
`timescale 1ns / 1ps

module vkt_checker
	import vkt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [KEY_W-1:0]  key,
	input  logic [VER_W-1:0]  version,
	input  logic [OFF_W-1:0]  info_offset,
	input  logic [LEN_W-1:0]  info_length,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic [STS_W-1:0]  status,
	input  logic [KEY_W-1:0]  entry_key,
	input  logic [VER_W-1:0]  entry_version,
	input  logic [OFF_W-1:0]  entry_offset,
	input  logic [LEN_W-1:0]  entry_length,
	input  logic [RCNT_W-1:0] removed_count,
	input  logic              last,
	output int                mismatches,
	output int                results_owed
);

	entry_t shadow_tab [TABLE_DEPTH];
	int     shadow_cnt;
	res_t   owed_results [$];
	int     err_cnt;

	initial begin
		err_cnt = 0;
		shadow_cnt = 0;
	end

	task automatic report(input string what);
		$display("vkt_checker: mismatch at %0t ns: %s", $time, what);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// oldest entry sits in slot 0; removal shifts the newer ones down
	task automatic drop_slot(input int idx);
		for (int j = idx; j < shadow_cnt - 1; j++)
			shadow_tab[j] = shadow_tab[j + 1];
		shadow_cnt--;
	endtask

	task automatic apply_to_table(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VER_W-1:0] v, input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] len);
		logic [VER_W-1:0] newest_ver;
		int               removed;
		res_t             r;
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_INSERT: begin
				if (shadow_cnt >= TABLE_DEPTH) begin
					r.status = STS_FULL;
				end else begin
					newest_ver = '0;
					for (int i = 0; i < shadow_cnt; i++)
						if (shadow_tab[i].key == k && shadow_tab[i].version > newest_ver)
							newest_ver = shadow_tab[i].version;
					// versions stick at the top value
					if (newest_ver != VERSION_MAX)
						newest_ver = newest_ver + VER_W'(1);
					shadow_tab[shadow_cnt] = '{key: k, version: newest_ver,
						offset: off, length: len};
					shadow_cnt++;
					r.status = STS_INSERTED;
					r.ent.version = newest_ver;
				end
				owed_results.push_back(r);
			end
			OP_DELETE: begin
				removed = 0;
				if (v != '0) begin
					// only the newest match goes
					for (int i = shadow_cnt - 1; i >= 0; i--) begin
						if (shadow_tab[i].key == k && shadow_tab[i].version == v) begin
							drop_slot(i);
							removed = 1;
							break;
						end
					end
				end else begin
					for (int i = shadow_cnt - 1; i >= 0; i--) begin
						if (shadow_tab[i].key == k) begin
							drop_slot(i);
							removed++;
						end
					end
				end
				r.status = (removed != 0) ? STS_DELETED : STS_NOT_FOUND;
				r.removed = removed[RCNT_W-1:0];
				owed_results.push_back(r);
			end
			OP_VIEW: begin
				if (shadow_cnt == 0) begin
					r.status = STS_EMPTY;
					owed_results.push_back(r);
				end else begin
					for (int i = shadow_cnt - 1; i >= 0; i--) begin
						r = '0;
						r.status = STS_ENTRY;
						r.ent = shadow_tab[i];
						r.last = (i == 0);
						owed_results.push_back(r);
					end
				end
			end
			default: ;  // unused code: no change, no result
		endcase
	endtask

	task automatic check_result();
		res_t want;
		if (owed_results.size() == 0) begin
			report($sformatf("unexpected result, status %0d", status));
		end else begin
			want = owed_results.pop_front();
			check_field("status", 32'(status), 32'(want.status));
			check_field("entry_key", entry_key, want.ent.key);
			check_field("entry_version", 32'(entry_version), 32'(want.ent.version));
			check_field("entry_offset", 32'(entry_offset), 32'(want.ent.offset));
			check_field("entry_length", 32'(entry_length), 32'(want.ent.length));
			check_field("removed_count", 32'(removed_count), 32'(want.removed));
			check_field("last", 32'(last), 32'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cnt = 0;
			owed_results.delete();
			results_owed <= 0;
			mismatches <= 0;
		end else begin
			// a result can never belong to a request taken at the same edge
			if (rsp_valid && rsp_ready)
				check_result();
			if (req_valid && req_ready)
				apply_to_table(operation, key, version, info_offset, info_length);
			results_owed <= owed_results.size();
			mismatches <= err_cnt;
		end
	end

endmodule

@@ bench/tb.sv @@
// tb: drives requests into versioned_key_table_core and drains its results with
// random gaps and one long result stall. Depends on vkt_pkg, the core and vkt_checker.
`timescale 1ns / 1ps

module tb;
	import vkt_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEFAULT;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [OP_W-1:0]   operation = '0;
	logic [KEY_W-1:0]  key = '0;
	logic [VER_W-1:0]  version = '0;
	logic [OFF_W-1:0]  info_offset = '0;
	logic [LEN_W-1:0]  info_length = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [STS_W-1:0]  status;
	logic [KEY_W-1:0]  entry_key;
	logic [VER_W-1:0]  entry_version;
	logic [OFF_W-1:0]  entry_offset;
	logic [LEN_W-1:0]  entry_length;
	logic [RCNT_W-1:0] removed_count;
	logic              last;

	int mismatches;
	int results_owed;
	int n_by_op [4];
	int n_sent;
	int n_results;
	logic [KEY_W-1:0] keys_seen [$];

	always #10 clk = ~clk;

	versioned_key_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (.*);

	vkt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

	// sender: every request waits a random idle gap, except runs of back-to-back ones
	task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VER_W-1:0] v, input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] len);
		int  gap;
		bit  known;
		gap = (n_sent % 32 < 8) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key <= k;
		version <= v;
		info_offset <= off;
		info_length <= len;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		n_by_op[op]++;
		n_sent++;
		// remember inserted keys so the table can be emptied later
		if (op == OP_INSERT) begin
			known = 0;
			foreach (keys_seen[i])
				if (keys_seen[i] == k) known = 1;
			if (!known) keys_seen.push_back(k);
		end
	endtask

	// sender pause until every owed result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	// small pool so keys collide and versions climb
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			8, 9: return $urandom;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	task automatic random_req();
		int               pick;
		logic [OP_W-1:0]  op;
		logic [VER_W-1:0] v;
		logic [OFF_W-1:0] off;
		pick = $urandom_range(0, 99);
		op = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_DELETE :
			(pick < 92) ? OP_VIEW : OP_UNUSED;
		case ($urandom_range(0, 5))
			0, 1: v = '0;
			2, 3: v = VER_W'($urandom_range(1, 4));
			4: v = VERSION_MAX;
			default: v = VER_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: off = '0;
			1: off = '1;
			default: off = OFF_W'($urandom);
		endcase
		send_req(op, pick_key(), v, off, ($urandom_range(0, 3) == 0) ? 7'd79 :
			7'($urandom_range(0, 127)));
	endtask

	// receiver: random stalls, runs with ready held high, and one long hold-off
	// that backs the core up while the sender keeps offering requests
	initial begin
		int pause;
		bit long_hold_done;
		long_hold_done = 0;
		n_results = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && n_results >= 50) begin
				pause = 400;
				long_hold_done = 1;
			end else begin
				pause = (n_results % 40 < 10) ? 0 : $urandom_range(0, 10);
			end
			if (pause > 0) begin
				rsp_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			n_results++;
		end
	end

	initial begin
		int inserts;
		n_sent = 0;
		foreach (n_by_op[i]) n_by_op[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes of fields, version climb, every delete form
		send_req(OP_VIEW, '0, '0, '0, '0);
		send_req(OP_DELETE, 32'd5, '0, '0, '0);
		send_req(OP_DELETE, 32'd5, 31'd3, '0, '0);
		send_req(OP_INSERT, 32'h8000_0000, '0, '0, 7'd0);
		send_req(OP_INSERT, 32'h7FFF_FFFF, '1, '1, 7'd79);
		send_req(OP_INSERT, '0, '0, OFF_W'($urandom), 7'd127);
		send_req(OP_INSERT, '1, '0, 31'd1, 7'd80);
		send_req(OP_INSERT, 32'h8000_0000, '0, 31'h2AAA_AAAA, 7'd42);
		send_req(OP_INSERT, 32'h8000_0000, '0, 31'h5555_5555, 7'd85);
		send_req(OP_VIEW, '0, '0, '0, '0);
		send_req(OP_DELETE, 32'h8000_0000, 31'd2, '0, '0);
		send_req(OP_DELETE, 32'h8000_0000, 31'd2, '0, '0);
		send_req(OP_DELETE, 32'h8000_0000, VERSION_MAX, '0, '0);
		send_req(OP_INSERT, 32'h8000_0000, '0, 31'd7, 7'd1);
		send_req(OP_UNUSED, 32'h8000_0000, '0, '0, '0);
		send_req(OP_DELETE, 32'h8000_0000, '0, '0, '0);
		send_req(OP_DELETE, '0, 31'd1, '0, '0);
		send_req(OP_VIEW, '0, '0, '0, '0);
		send_req(OP_DELETE, '1, 31'h5555_5555, '0, '0);
		send_req(OP_INSERT, 32'h7FFF_FFFF, '0, 31'h2AAA_AAAA, 7'd42);
		send_req(OP_VIEW, '0, '0, '0, '0);
		send_req(OP_UNUSED, $urandom, VER_W'($urandom), OFF_W'($urandom), 7'($urandom));
		wait_drained();

		// mixed random traffic over the key pool
		repeat (12) random_req();
		wait_drained();

		// empty the table, then fill it past capacity with views in between
		foreach (keys_seen[i])
			send_req(OP_DELETE, keys_seen[i], '0, OFF_W'($urandom), 7'($urandom));
		inserts = 0;
		while (inserts < TABLE_DEPTH + 3) begin
			if ($urandom_range(0, 11) == 0) begin
				send_req(OP_VIEW, $urandom, VER_W'($urandom), OFF_W'($urandom),
					7'($urandom));
			end else begin
				send_req(OP_INSERT, pick_key(), VER_W'($urandom), OFF_W'($urandom),
					7'($urandom_range(0, 127)));
				inserts++;
			end
		end
		send_req(OP_VIEW, '0, '0, '0, '0);
		send_req(OP_DELETE, 32'd1, 31'd1, '0, '0);
		send_req(OP_INSERT, 32'd1, '0, '1, 7'd79);
		send_req(OP_INSERT, 32'd1, '0, '0, 7'd0);

		repeat (6) random_req();
		wait_drained();
		repeat (200) @(posedge clk);

		$display("tb: %0d inserts, %0d deletes, %0d views, %0d unused codes sent",
			n_by_op[OP_INSERT], n_by_op[OP_DELETE], n_by_op[OP_VIEW], n_by_op[OP_UNUSED]);
		$display("tb: %0d results checked, table run to full and refused inserts",
			n_results);
		if (mismatches == 0 && results_owed == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
